// ===== hw/rtl/cbr_pkg.sv =====
// shared constants, types and the line length table of the comb bank reverb
`default_nettype none

package cbr_pkg;

  localparam int TAPS        = 4;
  localparam int FRAC_BITS   = 12;
  localparam int LINE_DEPTH  = 1024;
  localparam int STORE_WIDTH = 20;

  localparam int NUM_LINES  = 4;
  localparam int LINE_SEL_W = $clog2(NUM_LINES);
  localparam int PTR_W      = $clog2(LINE_DEPTH);
  localparam int ADDR_W     = LINE_SEL_W + PTR_W;
  localparam int MEM_DEPTH  = NUM_LINES * LINE_DEPTH;

  localparam int SAMPLE_W   = 13;
  localparam int GAIN_W     = 13;
  localparam int ROOM_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [ROOM_W-1:0] MAX_ROOM   = 4'd8;
  localparam logic [ROOM_W-1:0] ROOM_RESET = 4'd3;
  localparam logic [GAIN_W-1:0] MIX_RESET  = 13'd2048;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOM_SIZE = 3'd0,
    CFG_TAP0_GAIN = 3'd1,
    CFG_TAP1_GAIN = 3'd2,
    CFG_TAP2_GAIN = 3'd3,
    CFG_TAP3_GAIN = 3'd4,
    CFG_MIX_GAIN  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [ROOM_W-1:0]                 room_size;
    logic [NUM_LINES-1:0][GAIN_W-1:0]  tap_gain;
    logic [GAIN_W-1:0]                 mix_gain;
  } cfg_t;

  typedef struct packed {
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [STORE_WIDTH-1:0] wr_data;
  } mem_req_t;

  // prime delay lengths, indexed by room size plus tap offset
  function automatic logic [PTR_W-1:0] prime_len(input logic [3:0] idx);
    logic [PTR_W-1:0] len;
    unique case (idx)
      4'd0:    len = 10'd241;
      4'd1:    len = 10'd269;
      4'd2:    len = 10'd293;
      4'd3:    len = 10'd331;
      4'd4:    len = 10'd367;
      4'd5:    len = 10'd409;
      4'd6:    len = 10'd457;
      4'd7:    len = 10'd509;
      4'd8:    len = 10'd563;
      4'd9:    len = 10'd631;
      4'd10:   len = 10'd701;
      4'd11:   len = 10'd773;
      4'd12:   len = 10'd863;
      4'd13:   len = 10'd953;
      default: len = 10'd953;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cbr_if.sv =====
// valid/ready stream interfaces for the sample input and output channels
`default_nettype none

interface cbr_in_if;
  import cbr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface cbr_out_if;
  import cbr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cbr_delay_mem.sv =====
// delay line store: one synchronous ram with a clearing pass after reset
`default_nettype none

module cbr_delay_mem import cbr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mem_req_t               req,
  output logic [STORE_WIDTH-1:0]      rdata,
  output logic                        init_done
);

  logic [STORE_WIDTH-1:0] store_mem [MEM_DEPTH];
  logic [STORE_WIDTH-1:0] rdata_r;
  logic [ADDR_W:0]        clr_cnt_r;
  logic [ADDR_W:0]        clr_cnt_nxt;
  logic                   clearing;

  assign clearing    = !clr_cnt_r[ADDR_W];
  assign clr_cnt_nxt = clearing ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      store_mem[clr_cnt_r[ADDR_W-1:0]] <= '0;
    end else if (req.wr_en) begin
      store_mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= store_mem[req.rd_addr];
    end
  end

  assign rdata     = rdata_r;
  assign init_done = !clearing;

  // once cleared the store stays usable until the next reset
  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    init_done |=> init_done)
    else $error("clearing pass restarted without reset");

endmodule

`default_nettype wire

// ===== hw/rtl/cbr_comb_core.sv =====
// comb sequencer: pointer update, read-multiply-writeback per tap, mix and output
`default_nettype none

module cbr_comb_core import cbr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire logic                   init_done,
  output mem_req_t                    mem_req,
  input  wire logic [STORE_WIDTH-1:0] mem_rdata,
  cbr_in_if.sink                      in_chan,
  cbr_out_if.source                   out_chan
);

  localparam int PROD_W = STORE_WIDTH + GAIN_W + 1;
  localparam int X_W    = PROD_W - FRAC_BITS;
  localparam int WSUM_W = X_W + 1;
  localparam int SUM_W  = X_W + LINE_SEL_W;
  localparam int MIX_W  = SUM_W + GAIN_W + 1;
  localparam int RES_W  = MIX_W - FRAC_BITS + 1;

  localparam logic signed [WSUM_W-1:0] ST_MAX =
    $signed({{(WSUM_W-STORE_WIDTH+1){1'b0}}, {(STORE_WIDTH-1){1'b1}}});
  localparam logic signed [WSUM_W-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [RES_W-1:0] OUT_MAX =
    $signed({{(RES_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}});
  localparam logic signed [RES_W-1:0] OUT_MIN = ~OUT_MAX;
  localparam logic [LINE_SEL_W-1:0] LAST_TAP = LINE_SEL_W'(TAPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } core_state_t;

  core_state_t                state_r, state_nxt;
  logic [LINE_SEL_W-1:0]      k_r, k_nxt;
  logic [PTR_W-1:0]           line_ptr_r [NUM_LINES];
  logic [PTR_W-1:0]           line_ptr_nxt [NUM_LINES];
  logic signed [SAMPLE_W-1:0] dry_r, dry_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic                       v1_r, v2_r;
  logic [LINE_SEL_W-1:0]      k1_r;
  logic [ADDR_W-1:0]          a1_r, a2_r;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [MIX_W-1:0]    mix_r, mix_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  logic                       accept, issue, pipe_empty, load_out;
  logic [ROOM_W-1:0]          size_eff;
  logic [3:0]                 len_idx;
  logic [PTR_W-1:0]           cur_len, cur_ptr, ptr_next;
  logic [PTR_W:0]             ptr_inc;
  logic signed [X_W-1:0]      x_val;
  logic signed [WSUM_W-1:0]   wsum;
  logic [STORE_WIDTH-1:0]     wr_val;
  logic signed [RES_W-1:0]    res;
  logic signed [SAMPLE_W-1:0] res_clamped;

  assign accept     = in_chan.valid && in_chan.ready;
  assign issue      = (state_r == ST_ISSUE);
  assign pipe_empty = !v1_r && !v2_r;
  assign load_out   = (state_r == ST_FINISH) && (!out_valid_r || out_chan.ready);

  // line length and pointer wrap for the tap being issued
  always_comb begin
    size_eff = (cfg.room_size > MAX_ROOM) ? MAX_ROOM : cfg.room_size;
    len_idx  = size_eff + 4'(k_r) + ((k_r != '0) ? 4'd2 : 4'd0);
    cur_len  = prime_len(len_idx);
    cur_ptr  = line_ptr_r[k_r];
    ptr_inc  = {1'b0, cur_ptr} + 1'b1;
    ptr_next = (ptr_inc >= {1'b0, cur_len}) ? '0 : ptr_inc[PTR_W-1:0];
    for (int i = 0; i < NUM_LINES; i++) begin
      line_ptr_nxt[i] = line_ptr_r[i];
    end
    if (issue) begin
      line_ptr_nxt[k_r] = ptr_next;
    end
  end

  // stage 1: scale the cell read back from the store
  assign prod_nxt = $signed(mem_rdata) * $signed({1'b0, cfg.tap_gain[k1_r]});

  // stage 2: floor shift, feed back the dry sample and saturate
  always_comb begin
    x_val = $signed(prod_r[PROD_W-1:FRAC_BITS]);
    wsum  = WSUM_W'(dry_r) + WSUM_W'(x_val);
    if (wsum > ST_MAX) begin
      wr_val = ST_MAX[STORE_WIDTH-1:0];
    end else if (wsum < ST_MIN) begin
      wr_val = ST_MIN[STORE_WIDTH-1:0];
    end else begin
      wr_val = wsum[STORE_WIDTH-1:0];
    end
  end

  always_comb begin
    mem_req.rd_en   = issue;
    mem_req.rd_addr = {k_r, cur_ptr};
    mem_req.wr_en   = v2_r;
    mem_req.wr_addr = a2_r;
    mem_req.wr_data = wr_val;
  end

  // final mix and clamp
  always_comb begin
    res = RES_W'(dry_r) + RES_W'($signed(mix_r[MIX_W-1:FRAC_BITS]));
    if (res > OUT_MAX) begin
      res_clamped = OUT_MAX[SAMPLE_W-1:0];
    end else if (res < OUT_MIN) begin
      res_clamped = OUT_MIN[SAMPLE_W-1:0];
    end else begin
      res_clamped = res[SAMPLE_W-1:0];
    end
  end

  assign mix_nxt = $signed(sum_r) * $signed({1'b0, cfg.mix_gain});

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    dry_nxt        = dry_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    if (v2_r) begin
      sum_nxt = sum_r + SUM_W'(x_val);
    end
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          dry_nxt   = in_chan.sample_in;
          sum_nxt   = '0;
          k_nxt     = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        k_nxt = k_r + 1'b1;
        if (k_r == LAST_TAP) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = res_clamped;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LINES; i++) begin
        line_ptr_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_LINES; i++) begin
        line_ptr_r[i] <= line_ptr_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    dry_r        <= dry_nxt;
    sum_r        <= sum_nxt;
    k1_r         <= k_r;
    a1_r         <= mem_req.rd_addr;
    a2_r         <= a1_r;
    prod_r       <= prod_nxt;
    out_sample_r <= out_sample_nxt;
    if (state_r == ST_DRAIN) begin
      mix_r <= mix_nxt;
    end
  end

  assign in_chan.ready       = (state_r == ST_IDLE) && init_done;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_sample_r;

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> !mem_req.wr_en)
    else $error("delay store written during clearing pass");

  a_accept_starts_issue: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_ISSUE) && (k_r == '0))
    else $error("accepted sample did not start tap issue");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("writeback without a preceding read");

  a_no_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
    else $error("read and write of one delay cell in the same cycle");

endmodule

`default_nettype wire

// ===== hw/rtl/comb_bank_reverb.sv =====
// top level of the comb bank reverb: configuration registers and block wiring
//
// four parallel feedback comb filters over 13-bit signed samples. each input
// transaction carries one dry sample and yields exactly one output transaction
// with dry plus scaled comb sum, clamped to 13 bits. all four delay lines live
// in one 4096 x 20-bit single-read, single-write ram; the four taps are read on
// consecutive cycles through its one read port, scaled by a 13 x 20 multiplier
// and written back through the read data and product registers, then the summed
// taps go through the mix multiplier. a new sample is accepted only once the
// previous one has reached the output register; the output register lets the
// next sample in while the previous result waits. after reset all 4096 cells of
// the ram are zeroed by a clearing pass during which in_chan.ready stays
// low. configuration registers are written through cfg_we / cfg_index /
// cfg_wdata (room size, four tap gains, mix gain) and should change only
// while no sample is in flight.
`default_nettype none

module comb_bank_reverb import cbr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  cbr_in_if.sink                     in_chan,
  cbr_out_if.source                  out_chan
);

  cfg_t                   cfg_r, cfg_nxt;
  mem_req_t               mem_req;
  logic [STORE_WIDTH-1:0] mem_rdata;
  logic                   init_done;

  // register writes; unknown indexes leave everything unchanged
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROOM_SIZE: cfg_nxt.room_size   = cfg_wdata[ROOM_W-1:0];
        CFG_TAP0_GAIN: cfg_nxt.tap_gain[0] = cfg_wdata[GAIN_W-1:0];
        CFG_TAP1_GAIN: cfg_nxt.tap_gain[1] = cfg_wdata[GAIN_W-1:0];
        CFG_TAP2_GAIN: cfg_nxt.tap_gain[2] = cfg_wdata[GAIN_W-1:0];
        CFG_TAP3_GAIN: cfg_nxt.tap_gain[3] = cfg_wdata[GAIN_W-1:0];
        CFG_MIX_GAIN:  cfg_nxt.mix_gain    = cfg_wdata[GAIN_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.room_size <= ROOM_RESET;
      cfg_r.tap_gain  <= '0;
      cfg_r.mix_gain  <= MIX_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // delay line ram with its reset clearing pass
  cbr_delay_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mem_req),
    .rdata     (mem_rdata),
    .init_done (init_done)
  );

  // tap sequencer, feedback arithmetic, mix and output register
  cbr_comb_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .init_done (init_done),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire
